### hdl/ogfd_pkg.sv
// Package with cell classes, register indexes and the cell classifier for the frontier detector.
package ogfd_pkg;

  typedef logic [1:0] cls_t;

  localparam cls_t CLS_FREE     = 2'd0;
  localparam cls_t CLS_UNKNOWN  = 2'd1;
  localparam cls_t CLS_OCCUPIED = 2'd2;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int INDEX_W     = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  localparam logic [7:0] VALUE_UNKNOWN  = 8'hFF;
  localparam logic [7:0] VALUE_OCCUPIED = 8'd100;

  function automatic cls_t classify(input logic signed [7:0] value);
    cls_t result;
    if (value == VALUE_UNKNOWN) begin
      result = CLS_UNKNOWN;
    end else if (value == VALUE_OCCUPIED) begin
      result = CLS_OCCUPIED;
    end else begin
      result = CLS_FREE;
    end
    return result;
  endfunction

endpackage

### hdl/occupancy_grid_frontier_detect.sv
// Streaming 4-neighbour frontier detector for raster-ordered occupancy-grid cells.
//
// The input channel (in_valid, in_ready, cell_value) takes one grid cell per
// transaction in raster order. Every input transaction yields exactly one output
// transaction (out_valid, out_ready) carrying decided, frontier_flag, cell_index
// and frame_last. When the cell below a centre arrives, the centre is judged.
// One cell is taken every cycle while the output side keeps up. The result of
// a cell passes through the line-store read stage and then the output register.
// The line stores sit in one memory with two read ports and one write port;
// a read-modify-write per cell keeps the rate.
// When the receiver stalls, the output register and the read stage each hold one
// result, after which in_ready drops until the output drains.
// Reset is synchronous and clears the pipeline, counters and window and sets both
// dimensions to their maximum, at most 4096. The line store has no reset and needs
// no clearing pass. Writing map_width or map_height while idle restarts the frame.
module occupancy_grid_frontier_detect
  import ogfd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [7:0]      cell_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   decided,
  output logic                   frontier_flag,
  output logic [INDEX_W-1:0]     cell_index,
  output logic                   frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WIDTH_RESET  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int HEIGHT_RESET = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;

  // Each entry holds {two rows above, row above}.
  logic [3:0] line_mem [MAX_WIDTH];
  logic [3:0] rd_a;
  logic [3:0] rd_b;

  logic [CW:0]   width_eff;
  logic [RW:0]   height_eff;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [INDEX_W-1:0] judge_index;
  cls_t          left_cls;

  logic               s1_valid;
  logic [CW-1:0]      s1_col;
  cls_t               s1_cls;
  logic               s1_decided;
  logic               s1_inner;
  logic               s1_right_ok;
  logic [INDEX_W-1:0] s1_index;
  logic               s1_last;

  logic          in_accept;
  logic          s1_advance;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          last_col;
  logic          last_row;
  cls_t          cls_in;
  cls_t          up_cls;
  cls_t          centre_cls;
  cls_t          right_cls;
  logic          any_occupied;
  logic          any_unknown;
  logic          flag;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;

  assign cls_in   = classify(cell_value);
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;
  assign last_col = (col_inc == width_eff);
  assign last_row = (row_inc == height_eff);

  assign up_cls     = rd_a[3:2];
  assign centre_cls = rd_a[1:0];
  assign right_cls  = s1_right_ok ? rd_b[1:0] : CLS_FREE;

  always_comb begin
    any_occupied = (left_cls == CLS_OCCUPIED) || (right_cls == CLS_OCCUPIED) ||
                   (up_cls == CLS_OCCUPIED) || (s1_cls == CLS_OCCUPIED);
    any_unknown  = (left_cls == CLS_UNKNOWN) || (right_cls == CLS_UNKNOWN) ||
                   (up_cls == CLS_UNKNOWN) || (s1_cls == CLS_UNKNOWN);
    flag = s1_inner && (centre_cls != CLS_UNKNOWN) && !any_occupied && any_unknown;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_a <= line_mem[col];
      rd_b <= line_mem[col_inc[CW-1:0]];
    end
    if (s1_advance) begin
      line_mem[s1_col] <= {centre_cls, s1_cls};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff   <= (CW+1)'(WIDTH_RESET);
      height_eff  <= (RW+1)'(HEIGHT_RESET);
      col         <= '0;
      row         <= '0;
      judge_index <= '0;
      left_cls    <= CLS_FREE;
    end else if (cfg_we && (cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT)) begin
      if (cfg_index == REG_MAP_WIDTH) begin
        if (cfg_data < CFG_DATA_W'(3)) begin
          width_eff <= (CW+1)'(3);
        end else if (32'(cfg_data) > MAX_WIDTH) begin
          width_eff <= (CW+1)'(MAX_WIDTH);
        end else begin
          width_eff <= (CW+1)'(cfg_data);
        end
      end else begin
        if (cfg_data < CFG_DATA_W'(3)) begin
          height_eff <= (RW+1)'(3);
        end else if (32'(cfg_data) > MAX_HEIGHT) begin
          height_eff <= (RW+1)'(MAX_HEIGHT);
        end else begin
          height_eff <= (RW+1)'(cfg_data);
        end
      end
      col         <= '0;
      row         <= '0;
      judge_index <= '0;
      left_cls    <= CLS_FREE;
    end else begin
      if (in_accept) begin
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row_inc[RW-1:0];
        end else begin
          col <= col_inc[CW-1:0];
        end
        if (last_col && last_row) begin
          judge_index <= '0;
        end else if (row != '0) begin
          judge_index <= judge_index + 1'b1;
        end
      end
      if (s1_advance) begin
        left_cls <= centre_cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col      <= col;
      s1_cls      <= cls_in;
      s1_decided  <= (row != '0);
      s1_inner    <= (row > RW'(1)) && (col != '0) && !last_col;
      s1_right_ok <= !last_col;
      s1_index    <= (row != '0) ? judge_index : '0;
      s1_last     <= last_col && last_row;
    end
    if (s1_advance) begin
      decided       <= s1_decided;
      frontier_flag <= flag;
      cell_index    <= s1_index;
      frame_last    <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### tb/occupancy_grid_frontier_detect_test.sv
// Self-checking testbench for the occupancy-grid frontier detector, with its scoreboard.
`timescale 1ns / 100ps

module occupancy_grid_frontier_detect_test
  import ogfd_pkg::*;
();

  localparam int GRID_MAX_WIDTH  = 4096;
  localparam int GRID_MAX_HEIGHT = 4096;
  localparam int LONG_STALL      = 64;
  localparam int MAX_REPORTS     = 10;
  localparam int ITEMS_PER_MODE  = 280;
  localparam int TAIL_ITEMS      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_HI = 2'd3;

  typedef struct packed {
    logic               decided;
    logic               frontier;
    logic [INDEX_W-1:0] cell_index;
    logic               frame_last;
  } verdict_t;

  class frontier_scoreboard;
    cls_t                  line_above[GRID_MAX_WIDTH];
    cls_t                  line_two_above[GRID_MAX_WIDTH];
    cls_t                  window_left;
    cls_t                  window_centre;
    cls_t                  window_right;
    int unsigned           column_pos;
    int unsigned           row_pos;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    verdict_t              expected_verdicts[$];
    int unsigned           mismatch_count;

    function new();
      foreach (line_above[i]) begin
        line_above[i] = CLS_FREE;
        line_two_above[i] = CLS_FREE;
      end
      window_left = CLS_FREE;
      window_centre = CLS_FREE;
      window_right = CLS_FREE;
      column_pos = 0;
      row_pos = 0;
      width_reg = CFG_DATA_W'(GRID_MAX_WIDTH);
      height_reg = CFG_DATA_W'(GRID_MAX_HEIGHT);
      mismatch_count = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] raw, int unsigned limit);
      if (raw < 3) begin
        return 3;
      end
      return (raw > limit) ? limit : raw;
    endfunction

    // A write to either dimension starts a new frame; the line stores keep their data.
    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_MAP_WIDTH || index == REG_MAP_HEIGHT) begin
        if (index == REG_MAP_WIDTH) begin
          width_reg = data;
        end else begin
          height_reg = data;
        end
        column_pos = 0;
        row_pos = 0;
        window_left = CLS_FREE;
        window_centre = CLS_FREE;
        window_right = CLS_FREE;
      end
    endfunction

    function void judge_cell(logic [7:0] value);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      cls_t        below;
      cls_t        above;
      logic        occupied_near;
      logic        unknown_near;
      verdict_t    verdict;
      w = clamp_dim(width_reg, GRID_MAX_WIDTH);
      h = clamp_dim(height_reg, GRID_MAX_HEIGHT);
      c = (column_pos >= w) ? 0 : column_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      if (value == VALUE_UNKNOWN) begin
        below = CLS_UNKNOWN;
      end else if (value == VALUE_OCCUPIED) begin
        below = CLS_OCCUPIED;
      end else begin
        below = CLS_FREE;
      end
      window_left = window_centre;
      window_centre = line_above[c];
      window_right = (c + 1 < w) ? line_above[c + 1] : CLS_FREE;
      above = line_two_above[c];
      verdict = '0;
      verdict.frame_last = (r == h - 1) && (c == w - 1);
      if (r >= 1) begin
        verdict.decided = 1'b1;
        verdict.cell_index = INDEX_W'((r - 1) * w + c);
        if (window_centre != CLS_UNKNOWN && r != 1 && c != 0 && c != w - 1) begin
          occupied_near = window_left == CLS_OCCUPIED || window_right == CLS_OCCUPIED ||
                          above == CLS_OCCUPIED || below == CLS_OCCUPIED;
          unknown_near = window_left == CLS_UNKNOWN || window_right == CLS_UNKNOWN ||
                         above == CLS_UNKNOWN || below == CLS_UNKNOWN;
          verdict.frontier = !occupied_near && unknown_near;
        end
      end
      line_two_above[c] = line_above[c];
      line_above[c] = below;
      if (c + 1 >= w) begin
        column_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        column_pos = c + 1;
        row_pos = r;
      end
      expected_verdicts = {expected_verdicts, verdict};
    endfunction

    function void check_result(logic d, logic f, logic [INDEX_W-1:0] idx, logic l);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result: decided=%b frontier=%b index=%0d last=%b",
                   $realtime, d, f, idx, l);
        end
      end else begin
        want = expected_verdicts.pop_front();
        if (d !== want.decided || f !== want.frontier || idx !== want.cell_index ||
            l !== want.frame_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch: expected decided=%b frontier=%b index=%0d last=%b",
                     $realtime, want.decided, want.frontier, want.cell_index, want.frame_last);
            $display("%0t:                  got      decided=%b frontier=%b index=%0d last=%b",
                     $realtime, d, f, idx, l);
          end
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [7:0]      cell_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   decided;
  logic                   frontier_flag;
  logic [INDEX_W-1:0]     cell_index;
  logic                   frame_last;

  frontier_scoreboard board;
  int unsigned        sender_idle_pct = 0;
  int unsigned        receiver_idle_pct = 0;
  bit                 long_stall_request = 1'b0;
  int unsigned        stall_left = 0;

  occupancy_grid_frontier_detect uut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (long_stall_request) begin
      long_stall_request = 1'b0;
      stall_left = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(decided, frontier_flag, cell_index, frame_last);
    end
  end

  function automatic logic [7:0] random_cell();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return VALUE_UNKNOWN;
    end else if (pick < 45) begin
      return VALUE_OCCUPIED;
    end else if (pick < 90) begin
      return 8'($urandom_range(99));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return CFG_DATA_W'($urandom_range(2));
    end else if (pick == 1) begin
      return CFG_DATA_W'($urandom_range(40, 11));
    end
    return CFG_DATA_W'($urandom_range(10, 3));
  endfunction

  task automatic send_cell(input logic [7:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cell_value <= value;
    do @(posedge clk); while (!in_ready);
    board.judge_cell(value);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_register(index, data);
    @(negedge clk);
  endtask

  task automatic pick_grid_size();
    int unsigned choice;
    choice = $urandom_range(9);
    if (choice < 7) begin
      program_register(REG_MAP_WIDTH, random_dim());
      program_register(REG_MAP_HEIGHT, random_dim());
    end else if (choice == 7) begin
      program_register(REG_MAP_WIDTH, random_dim());
    end else if (choice == 8) begin
      program_register(REG_MAP_HEIGHT, random_dim());
    end else begin
      // A write to a spare index must leave the current frame running.
      program_register($urandom_range(1) ? REG_RESERVED_LO : REG_RESERVED_HI,
                       CFG_DATA_W'($urandom_range(8191)));
    end
  endtask

  task automatic send_random_cells(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_cell(random_cell());
    end
  endtask

  initial begin
    logic [7:0]  row_zero_cells[5];
    logic [7:0]  small_frames[18];
    int unsigned items_left;
    int unsigned batch;
    row_zero_cells = '{VALUE_UNKNOWN, VALUE_OCCUPIED, 8'h00, 8'h7F, 8'h80};
    small_frames = '{8'd0, VALUE_UNKNOWN, 8'd99,
                     8'd101, 8'd0, 8'd42,
                     8'd0, 8'd1, 8'hC0,
                     VALUE_UNKNOWN, VALUE_UNKNOWN, VALUE_UNKNOWN,
                     8'd0, 8'd50, VALUE_OCCUPIED,
                     VALUE_UNKNOWN, VALUE_UNKNOWN, VALUE_UNKNOWN};
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct = 25;
    receiver_idle_pct = 56;

    foreach (row_zero_cells[i]) begin
      send_cell(row_zero_cells[i]);
    end
    wait_quiet();
    program_register(REG_MAP_WIDTH, 13'd3);
    program_register(REG_MAP_HEIGHT, 13'd2);
    foreach (small_frames[i]) begin
      send_cell(small_frames[i]);
    end

    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 56 : 0;
      receiver_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 25 : 0;
      items_left = ITEMS_PER_MODE;
      while (items_left != 0) begin
        batch = $urandom_range(80, 20);
        if (batch > items_left) begin
          batch = items_left;
        end
        wait_quiet();
        pick_grid_size();
        if (items_left == ITEMS_PER_MODE && mode != 1) begin
          long_stall_request = 1'b1;
        end
        if ($urandom_range(3) == 0) begin
          send_random_cells(batch / 2);
          wait_quiet();
          program_register(REG_RESERVED_HI, CFG_DATA_W'($urandom_range(8191)));
          send_random_cells(batch - batch / 2);
        end else begin
          send_random_cells(batch);
        end
        items_left -= batch;
      end
    end

    wait_quiet();
    program_register(REG_MAP_WIDTH, 13'd4096);
    program_register(REG_MAP_HEIGHT, 13'd0);
    send_random_cells(TAIL_ITEMS);
    wait_quiet();
    program_register(REG_MAP_WIDTH, 13'd3);
    program_register(REG_MAP_HEIGHT, 13'd4097);
    send_random_cells(TAIL_ITEMS);

    in_valid <= 1'b0;
    for (int k = 0; k < 2000 && board.expected_verdicts.size() != 0; k++) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (board.expected_verdicts.size() != 0) begin
      $display("%0d expected results never arrived", board.expected_verdicts.size());
      board.mismatch_count += board.expected_verdicts.size();
    end
    if (board.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d results outstanding", board.expected_verdicts.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/ogfd_pkg.sv
hdl/occupancy_grid_frontier_detect.sv
tb/occupancy_grid_frontier_detect_test.sv
